@@ rtl/core/u16u8_pkg.sv @@
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types, constants and the byte formatter for the UTF-16 to UTF-8
// encoder.
// ----------------------------------------------------------------------------
package u16u8_pkg;

  localparam int UNIT_W  = 16;
  localparam int CP_W    = 21;
  localparam int BYTE_W  = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [UNIT_W-1:0] HIGH_SURR_FIRST = 16'hD800;
  localparam logic [UNIT_W-1:0] HIGH_SURR_LAST  = 16'hDBFF;
  localparam logic [CP_W-1:0]   SUPP_BASE       = 21'h10000;
  localparam logic [CP_W-1:0]   MAX_ONE_BYTE    = 21'h00007F;
  localparam logic [CP_W-1:0]   MAX_TWO_BYTE    = 21'h0007FF;
  localparam logic [CP_W-1:0]   MAX_THREE_BYTE  = 21'h00FFFF;

  localparam logic [BYTE_W-1:0] LEAD_TWO   = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD_THREE = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD_FOUR  = 8'hF0;
  localparam logic [BYTE_W-1:0] CONT_MARK  = 8'h80;

  // Encoded length minus one.
  localparam logic [1:0] LEN_ONE   = 2'd0;
  localparam logic [1:0] LEN_TWO   = 2'd1;
  localparam logic [1:0] LEN_THREE = 2'd2;
  localparam logic [1:0] LEN_FOUR  = 2'd3;

  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic [1:0]      len;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } queue_head_t;

  function automatic logic [BYTE_W-1:0] format_byte(input logic [CP_W-1:0] cp,
                                                    input logic [1:0] len,
                                                    input logic [1:0] idx);
    logic [1:0] remain;
    logic [BYTE_W-1:0] result;
    remain = len - idx;
    result = '0;
    if (idx == 2'd0) begin
      unique case (len)
        LEN_ONE:   result = {1'b0, cp[6:0]};
        LEN_TWO:   result = LEAD_TWO | {3'b000, cp[10:6]};
        LEN_THREE: result = LEAD_THREE | {4'b0000, cp[15:12]};
        LEN_FOUR:  result = LEAD_FOUR | {5'b00000, cp[20:18]};
        default:   result = '0;
      endcase
    end else begin
      unique case (remain)
        2'd0:    result = CONT_MARK | {2'b00, cp[5:0]};
        2'd1:    result = CONT_MARK | {2'b00, cp[11:6]};
        2'd2:    result = CONT_MARK | {2'b00, cp[17:12]};
        default: result = CONT_MARK;
      endcase
    end
    return result;
  endfunction

endpackage

@@ rtl/core/u16u8_front.sv @@
// ----------------------------------------------------------------------------
// u16u8_front
// Accepts UTF-16 code units, pairs surrogates and classifies each code point
// by its encoded length.
// ----------------------------------------------------------------------------
module u16u8_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        unit_valid,
  output logic                        unit_stall,
  input  logic [u16u8_pkg::UNIT_W-1:0] code_unit,
  input  logic                        queue_full,
  output logic                        push,
  output u16u8_pkg::entry_t           push_entry
);
  import u16u8_pkg::*;

  logic       high_pending;
  logic [9:0] high_bits;
  logic       accept;
  logic       is_high;
  logic [CP_W-1:0] cp;

  assign unit_stall = queue_full;
  assign accept     = unit_valid && !queue_full;
  assign is_high    = (code_unit >= HIGH_SURR_FIRST) && (code_unit <= HIGH_SURR_LAST);

  always_comb begin
    if (high_pending) begin
      cp = {1'b0, high_bits, code_unit[9:0]} + SUPP_BASE;
    end else begin
      cp = {5'b00000, code_unit};
    end
    push_entry.cp = cp;
    if (cp <= MAX_ONE_BYTE) begin
      push_entry.len = LEN_ONE;
    end else if (cp <= MAX_TWO_BYTE) begin
      push_entry.len = LEN_TWO;
    end else if (cp <= MAX_THREE_BYTE) begin
      push_entry.len = LEN_THREE;
    end else begin
      push_entry.len = LEN_FOUR;
    end
  end

  assign push = accept && (high_pending || !is_high);

  always_ff @(posedge clk) begin
    if (rst) begin
      high_pending <= 1'b0;
      high_bits    <= '0;
    end else if (accept) begin
      if (high_pending) begin
        high_pending <= 1'b0;
        high_bits    <= '0;
      end else if (is_high) begin
        high_pending <= 1'b1;
        high_bits    <= code_unit[9:0];
      end
    end
  end

endmodule

@@ rtl/core/u16u8_queue.sv @@
// ----------------------------------------------------------------------------
// u16u8_queue
// Short first-word-fall-through queue of classified code points between the
// front and back parts.
// ----------------------------------------------------------------------------
module u16u8_queue #(
  parameter int DEPTH = u16u8_pkg::QUEUE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  u16u8_pkg::entry_t       push_entry,
  output logic                    full,
  input  logic                    pop,
  output u16u8_pkg::queue_head_t  head
);
  import u16u8_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  entry_t           entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head.valid = (count != '0);
  assign head.entry = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/u16u8_back.sv @@
// ----------------------------------------------------------------------------
// u16u8_back
// Serializes each queued code point into its UTF-8 bytes, one byte per
// cycle while byte_stall is low, through a registered output stage.
// ----------------------------------------------------------------------------
module u16u8_back (
  input  logic                         clk,
  input  logic                         rst,
  input  u16u8_pkg::queue_head_t       head,
  output logic                         pop,
  output logic                         byte_valid,
  input  logic                         byte_stall,
  output logic [u16u8_pkg::BYTE_W-1:0] out_byte,
  output logic                         end_of_char
);
  import u16u8_pkg::*;

  logic [1:0] idx;
  logic       out_free;
  logic       load;
  logic       last;

  assign out_free = !byte_valid || !byte_stall;
  assign load     = out_free && head.valid;
  assign last     = (idx == head.entry.len);
  assign pop      = load && last;

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte    <= format_byte(head.entry.cp, head.entry.len, idx);
      end_of_char <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
      idx        <= '0;
    end else begin
      if (out_free) begin
        byte_valid <= head.valid;
      end
      if (load) begin
        idx <= last ? 2'd0 : idx + 2'd1;
      end
    end
  end

endmodule

@@ rtl/core/utf16_to_utf8_encoder.sv @@
// ----------------------------------------------------------------------------
// utf16_to_utf8_encoder
// Converts a stream of UTF-16 code units into a stream of UTF-8 bytes.
// ----------------------------------------------------------------------------
// The input channel (unit_valid, unit_stall, code_unit) takes one code unit
// per request. The output channel (byte_valid, byte_stall, out_byte,
// end_of_char) gives one UTF-8 byte per request; end_of_char marks the last
// byte of each code point.
// A high surrogate produces no bytes and is joined with the unit that follows.
// The first byte of a unit passes through the queue and then the registered output stage.
// The output runs at one byte per cycle while byte_stall is low, and a code
// point yields one to four bytes by its encoded length; a surrogate pair
// yields four bytes for two units. The byte serializer sets the sustained rate.
// A queue of QUEUE_DEPTH code points sits between the input and the
// serializer, so the input keeps taking units while a byte waits.
// When the receiver stalls, the current byte holds and the queue fills;
// unit_stall rises once the queue is full.
// Reset empties the queue, drops a held high surrogate and clears byte_valid.
// ----------------------------------------------------------------------------
module utf16_to_utf8_encoder #(
  parameter int QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         unit_valid,
  output logic                         unit_stall,
  input  logic [u16u8_pkg::UNIT_W-1:0] code_unit,
  output logic                         byte_valid,
  input  logic                         byte_stall,
  output logic [u16u8_pkg::BYTE_W-1:0] out_byte,
  output logic                         end_of_char
);
  import u16u8_pkg::*;

  logic        queue_full;
  logic        push;
  entry_t      push_entry;
  logic        pop;
  queue_head_t head;

  u16u8_front u_front (
    .clk        (clk),
    .rst        (rst),
    .unit_valid (unit_valid),
    .unit_stall (unit_stall),
    .code_unit  (code_unit),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry)
  );

  u16u8_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .head       (head)
  );

  u16u8_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .pop         (pop),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .out_byte    (out_byte),
    .end_of_char (end_of_char)
  );

endmodule

@@ rtl/core/u16u8_checker.sv @@
// ----------------------------------------------------------------------------
// u16u8_checker
// Port-level checks on the UTF-8 byte stream of the encoder.
// ----------------------------------------------------------------------------
module u16u8_checker (
  input logic       clk,
  input logic       rst,
  input logic       byte_valid,
  input logic       byte_stall,
  input logic [7:0] out_byte,
  input logic       end_of_char
);

  logic at_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      at_start <= 1'b1;
    end else if (byte_valid && !byte_stall) begin
      at_start <= end_of_char;
    end
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> !byte_valid)
    else $error("byte_valid high after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    byte_valid && byte_stall |=> byte_valid && $stable(out_byte) && $stable(end_of_char))
    else $error("stalled byte changed");

  a_lead_position: assert property (@(posedge clk) disable iff (rst)
    byte_valid |-> (at_start == (out_byte[7:6] != 2'b10)))
    else $error("lead or continuation byte out of place");

  a_ascii_single: assert property (@(posedge clk) disable iff (rst)
    byte_valid && !out_byte[7] |-> end_of_char)
    else $error("ASCII byte not marked as end of character");

endmodule

bind utf16_to_utf8_encoder u16u8_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .byte_valid  (byte_valid),
  .byte_stall  (byte_stall),
  .out_byte    (out_byte),
  .end_of_char (end_of_char)
);
